// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker file of the straw neighbour finder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is high.
`define ASNF_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Clocked assertion that also holds through reset.
`define ASNF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) \
      else $error(msg);

`endif

// ===== hdl/asnf_pkg.sv =====
// ----------------------------------------------------------------------------
// asnf_pkg
// Shared types and fixed constants of the axial straw neighbour finder.
// ----------------------------------------------------------------------------
package asnf_pkg;

   // Configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 38;

   localparam logic [CSR_IDX_W-1:0] CSR_STRAW_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_DIST    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_AXIAL_TOL   = 2'd2;

   // Register widths and reset values
   localparam int CFG_COUNT_W = 14;
   localparam int DIST_W      = 38;
   localparam int TOL_W       = 21;

   localparam logic [CFG_COUNT_W-1:0] RST_STRAW_COUNT = 14'd8192;
   localparam logic [DIST_W-1:0]      RST_MAX_DIST    = 38'd1153434;
   localparam logic [TOL_W-1:0]       RST_AXIAL_TOL   = 21'd10;

   // Wire direction z, units 2^-20, and unity in an extended signed width
   localparam int DIR_W = 22;
   localparam logic signed [DIR_W+1:0] DIR_ONE = 24'sd1048576;

   // Item function codes
   localparam logic FUNC_LOAD  = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   // Tag carried alongside a straw through the distance pipeline
   typedef struct packed {
      logic valid;
      logic flag;
   } asnf_tag_type;

endpackage

// ===== hdl/asnf_dist.sv =====
// ----------------------------------------------------------------------------
// asnf_dist
// Distance pipeline: absolute xy differences, squares, then a sum compared
// against the squared distance limit. Two register stages.
// ----------------------------------------------------------------------------
module asnf_dist
   import asnf_pkg::*;
#(
   parameter int POS_WIDTH = 18,
   parameter int TAG_W     = 13
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        flush,
   input  asnf_tag_type                in_tag,      // flag = skip this straw
   input  logic [TAG_W-1:0]            in_slot,
   input  logic signed [POS_WIDTH-1:0] query_x,
   input  logic signed [POS_WIDTH-1:0] query_y,
   input  logic signed [POS_WIDTH-1:0] straw_x,
   input  logic signed [POS_WIDTH-1:0] straw_y,
   input  logic [DIST_W-1:0]           dist_limit,
   output asnf_tag_type                out_tag,     // flag = neighbour hit
   output logic [TAG_W-1:0]            out_slot,
   output logic                        pipe_busy
);

   localparam int DIFF_W = POS_WIDTH + 1;
   localparam int SQ_W   = 2 * DIFF_W;
   localparam int SUM_W  = SQ_W + 1;
   localparam int CMP_W  = (SUM_W > DIST_W) ? SUM_W : DIST_W;

   logic signed [DIFF_W-1:0] dx, dy;
   logic [DIFF_W-1:0]        ax_in, ay_in;
   logic [DIFF_W-1:0]        ax_ff, ay_ff;
   logic                     v1_ff, skip1_ff;
   logic [TAG_W-1:0]         slot1_ff;
   logic [SQ_W-1:0]          sqx_ff, sqy_ff;
   logic                     v2_ff, skip2_ff;
   logic [TAG_W-1:0]         slot2_ff;
   logic [SUM_W-1:0]         sum;

   // stage 1: absolute differences
   always_comb begin
      dx    = DIFF_W'(straw_x) - DIFF_W'(query_x);
      dy    = DIFF_W'(straw_y) - DIFF_W'(query_y);
      ax_in = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
      ay_in = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= in_tag.valid && !flush;
         v2_ff <= v1_ff && !flush;
      end
   end

   always_ff @(posedge clock) begin
      ax_ff    <= ax_in;
      ay_ff    <= ay_in;
      skip1_ff <= in_tag.flag;
      slot1_ff <= in_slot;
      // stage 2: squares
      sqx_ff   <= ax_ff * ax_ff;
      sqy_ff   <= ay_ff * ay_ff;
      skip2_ff <= skip1_ff;
      slot2_ff <= slot1_ff;
   end

   // sum and limit compare
   always_comb begin
      sum          = SUM_W'(sqx_ff) + SUM_W'(sqy_ff);
      out_tag.valid = v2_ff;
      out_tag.flag  = !skip2_ff && (CMP_W'(sum) <= CMP_W'(dist_limit));
   end

   assign out_slot  = slot2_ff;
   assign pipe_busy = v1_ff || v2_ff;

endmodule

// ===== hdl/axial_straw_neighbor_finder.sv =====
// ----------------------------------------------------------------------------
// axial_straw_neighbor_finder
// Stores straw positions and axial flags in one memory and answers
// fixed-radius neighbour queries by scanning every loaded straw.
// ----------------------------------------------------------------------------
//  channel   handshake               payload
//  req_      start / busy            func, straw_index, pos_x, pos_y, dir_z
//  rsp_      valid strobe, no stall  queried/neighbor number, count, flags
//  csr_      valid / ready           index, wdata
//
//  A load writes the straw memory on accept; busy stays low.
//  A query that is not axial or out of range is answered from the check state.
//  A scanning query reads one straw per cycle from the memory port, up to the
//  clamped straw_count; an overflow ends it early.
//  Reset is synchronous; the straw memory is not cleared and must be loaded.
//  Results are strobed for one cycle each; the receiver cannot stall.
// ----------------------------------------------------------------------------
module axial_straw_neighbor_finder
   import asnf_pkg::*;
#(
   parameter int MAX_STRAWS    = 8192,
   parameter int MAX_NEIGHBORS = 6,
   parameter int POS_WIDTH     = 18
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request
   input  logic                                 start,
   output logic                                 busy,
   input  logic                                 req_func,
   input  logic [$clog2(MAX_STRAWS)-1:0]        req_straw_index,
   input  logic signed [POS_WIDTH-1:0]          req_pos_x,
   input  logic signed [POS_WIDTH-1:0]          req_pos_y,
   input  logic signed [DIR_W-1:0]              req_dir_z,
   // response
   output logic                                 rsp_valid,
   output logic [$clog2(MAX_STRAWS+1)-1:0]      rsp_queried_number,
   output logic [$clog2(MAX_STRAWS+1)-1:0]      rsp_neighbor_number,
   output logic [$clog2(MAX_NEIGHBORS+1)-1:0]   rsp_neighbor_count,
   output logic                                 rsp_is_axial,
   output logic                                 rsp_overflow,
   output logic                                 rsp_last,
   // configuration
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [CSR_IDX_W-1:0]                 csr_index,
   input  logic [CSR_DATA_W-1:0]                csr_wdata
);

   localparam int IDX_W = $clog2(MAX_STRAWS);
   localparam int NUM_W = $clog2(MAX_STRAWS + 1);
   localparam int CNT_W = $clog2(MAX_NEIGHBORS + 1);
   localparam int LIM_W = (NUM_W > CFG_COUNT_W) ? NUM_W : CFG_COUNT_W;
   localparam int MEM_W = 2 * POS_WIDTH + 1;

   localparam logic [LIM_W-1:0] STRAWS_LIM = LIM_W'(MAX_STRAWS);
   localparam logic [CNT_W-1:0] CNT_FULL   = CNT_W'(MAX_NEIGHBORS);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_CHECK = 2'd1;
   localparam logic [1:0] ST_SCAN  = 2'd2;
   localparam logic [1:0] ST_OVF   = 2'd3;

   // configuration registers
   logic [CFG_COUNT_W-1:0] straw_count_ff;
   logic [DIST_W-1:0]      max_dist_ff;
   logic [TOL_W-1:0]       axial_tol_ff;

   // control state
   logic [1:0]       state_ff, state_in;
   logic [LIM_W-1:0] iss_ff, iss_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             v_rd_ff, issue;
   logic [IDX_W-1:0] slot_rd_ff;
   logic [IDX_W-1:0] qidx_ff;
   logic             qbad_ff;
   logic signed [POS_WIDTH-1:0] qx_ff, qy_ff;
   logic [NUM_W-1:0] pend_num_ff, pend_num_in;

   // memory
   logic [MEM_W-1:0] straw_mem [MAX_STRAWS];
   logic [MEM_W-1:0] rd_data_ff;
   logic [IDX_W-1:0] rd_addr;
   logic [MEM_W-1:0] wr_data;
   logic             wr_en;

   // request decode
   logic             accept, load_acc, query_acc;
   logic [LIM_W-1:0] limit, idx_ext, cfg_count_ext;
   logic signed [DIR_W+1:0] dz_off;
   logic [DIR_W+1:0]        dz_abs;
   logic                    load_axial;

   // distance pipeline
   asnf_tag_type     dist_in_tag, dist_out_tag;
   logic [IDX_W-1:0] dist_slot;
   logic             dist_busy;
   logic             scan_done;

   // response next values
   logic             rsp_valid_in;
   logic [NUM_W-1:0] rsp_qnum_in, rsp_nnum_in, qnum;
   logic [CNT_W-1:0] rsp_cnt_in;
   logic             rsp_axial_in, rsp_ovf_in, rsp_last_in;
   logic             rsp_valid_ff;
   logic [NUM_W-1:0] rsp_qnum_ff, rsp_nnum_ff;
   logic [CNT_W-1:0] rsp_cnt_ff;
   logic             rsp_axial_ff, rsp_ovf_ff, rsp_last_ff;

   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;
   assign load_acc  = accept && (req_func == FUNC_LOAD);
   assign query_acc = accept && (req_func == FUNC_QUERY);

   // scan length, clamped to the memory depth
   always_comb begin
      cfg_count_ext = LIM_W'(straw_count_ff);
      limit         = (cfg_count_ext > STRAWS_LIM) ? STRAWS_LIM : cfg_count_ext;
      idx_ext       = LIM_W'(req_straw_index);
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         straw_count_ff <= RST_STRAW_COUNT;
         max_dist_ff    <= RST_MAX_DIST;
         axial_tol_ff   <= RST_AXIAL_TOL;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_STRAW_COUNT: straw_count_ff <= csr_wdata[CFG_COUNT_W-1:0];
            CSR_MAX_DIST:    max_dist_ff    <= csr_wdata[DIST_W-1:0];
            CSR_AXIAL_TOL:   axial_tol_ff   <= csr_wdata[TOL_W-1:0];
            default: ;
         endcase
      end
   end

   // axial flag of a loaded straw: |dir_z - 1| within tolerance
   always_comb begin
      dz_off     = (DIR_W+2)'(req_dir_z) - DIR_ONE;
      dz_abs     = dz_off[DIR_W+1] ? (DIR_W+2)'(-dz_off) : (DIR_W+2)'(dz_off);
      load_axial = (dz_abs <= (DIR_W+2)'(axial_tol_ff));
      wr_data    = {load_axial, req_pos_y, req_pos_x};
      wr_en      = load_acc && (idx_ext < STRAWS_LIM);
   end

   // straw memory: one write port, one registered read port
   assign rd_addr = (state_ff == ST_IDLE) ? req_straw_index : iss_ff[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         straw_mem[req_straw_index] <= wr_data;
      end
      rd_data_ff <= straw_mem[rd_addr];
   end

   // distance pipeline hookup
   always_comb begin
      dist_in_tag.valid = v_rd_ff && (state_ff == ST_SCAN);
      dist_in_tag.flag  = (slot_rd_ff == qidx_ff) || !rd_data_ff[MEM_W-1];
   end

   asnf_dist #(
      .POS_WIDTH (POS_WIDTH),
      .TAG_W     (IDX_W)
   ) u_dist (
      .clock      (clock),
      .reset      (reset),
      .flush      (state_ff != ST_SCAN),
      .in_tag     (dist_in_tag),
      .in_slot    (slot_rd_ff),
      .query_x    (qx_ff),
      .query_y    (qy_ff),
      .straw_x    (rd_data_ff[POS_WIDTH-1:0]),
      .straw_y    (rd_data_ff[2*POS_WIDTH-1:POS_WIDTH]),
      .dist_limit (max_dist_ff),
      .out_tag    (dist_out_tag),
      .out_slot   (dist_slot),
      .pipe_busy  (dist_busy)
   );

   // sequencer: read issue, neighbour bookkeeping, result selection
   always_comb begin
      state_in     = state_ff;
      iss_in       = iss_ff;
      cnt_in       = cnt_ff;
      pend_num_in  = pend_num_ff;
      issue        = 1'b0;
      qnum         = NUM_W'(qidx_ff) + NUM_W'(1);
      scan_done    = (iss_ff >= limit) && !v_rd_ff && !dist_busy;
      rsp_valid_in = 1'b0;
      rsp_qnum_in  = qnum;
      rsp_nnum_in  = pend_num_ff;
      rsp_cnt_in   = cnt_ff;
      rsp_axial_in = 1'b1;
      rsp_ovf_in   = 1'b0;
      rsp_last_in  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (query_acc) begin
               state_in = ST_CHECK;
               iss_in   = '0;
               cnt_in   = '0;
            end
         end
         ST_CHECK: begin
            // queried straw is in rd_data_ff
            if (qbad_ff || !rd_data_ff[MEM_W-1]) begin
               rsp_valid_in = 1'b1;
               rsp_nnum_in  = '0;
               rsp_cnt_in   = '0;
               rsp_axial_in = 1'b0;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               issue    = 1'b1;
               iss_in   = iss_ff + LIM_W'(1);
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (iss_ff < limit) begin
               issue  = 1'b1;
               iss_in = iss_ff + LIM_W'(1);
            end
            if (dist_out_tag.valid && dist_out_tag.flag) begin
               if (cnt_ff == CNT_FULL) begin
                  // one too many: flush the held result, overflow follows
                  rsp_valid_in = 1'b1;
                  state_in     = ST_OVF;
               end else begin
                  // the held result is not the last one
                  rsp_valid_in = (cnt_ff != '0);
                  pend_num_in  = NUM_W'(dist_slot) + NUM_W'(1);
                  cnt_in       = cnt_ff + CNT_W'(1);
               end
            end else if (scan_done) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = 1'b1;
               if (cnt_ff == '0) begin
                  rsp_nnum_in = '0;
               end
               state_in = ST_IDLE;
            end
         end
         ST_OVF: begin
            rsp_valid_in = 1'b1;
            rsp_nnum_in  = '0;
            rsp_cnt_in   = CNT_FULL;
            rsp_ovf_in   = 1'b1;
            rsp_last_in  = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         iss_ff       <= '0;
         cnt_ff       <= '0;
         v_rd_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         iss_ff       <= iss_in;
         cnt_ff       <= cnt_in;
         v_rd_ff      <= issue;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (query_acc) begin
         qidx_ff <= req_straw_index;
         qbad_ff <= (idx_ext >= limit);
      end
      if (state_ff == ST_CHECK) begin
         qx_ff <= rd_data_ff[POS_WIDTH-1:0];
         qy_ff <= rd_data_ff[2*POS_WIDTH-1:POS_WIDTH];
      end
      slot_rd_ff   <= iss_ff[IDX_W-1:0];
      pend_num_ff  <= pend_num_in;
      rsp_qnum_ff  <= rsp_qnum_in;
      rsp_nnum_ff  <= rsp_nnum_in;
      rsp_cnt_ff   <= rsp_cnt_in;
      rsp_axial_ff <= rsp_axial_in;
      rsp_ovf_ff   <= rsp_ovf_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_queried_number  = rsp_qnum_ff;
   assign rsp_neighbor_number = rsp_nnum_ff;
   assign rsp_neighbor_count  = rsp_cnt_ff;
   assign rsp_is_axial        = rsp_axial_ff;
   assign rsp_overflow        = rsp_ovf_ff;
   assign rsp_last            = rsp_last_ff;

endmodule

// ===== hdl/asnf_checker.sv =====
// ----------------------------------------------------------------------------
// asnf_checker
// Port-level checks of the straw neighbour finder, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module asnf_checker
   import asnf_pkg::*;
#(
   parameter int MAX_STRAWS    = 8192,
   parameter int MAX_NEIGHBORS = 6,
   parameter int POS_WIDTH     = 18
) (
   input logic                               clock,
   input logic                               reset,
   input logic                               start,
   input logic                               busy,
   input logic                               req_func,
   input logic                               rsp_valid,
   input logic [$clog2(MAX_STRAWS+1)-1:0]    rsp_neighbor_number,
   input logic [$clog2(MAX_NEIGHBORS+1)-1:0] rsp_neighbor_count,
   input logic                               rsp_is_axial,
   input logic                               rsp_overflow,
   input logic                               rsp_last
);

   logic query_acc;
   assign query_acc = start && !busy && (req_func == FUNC_QUERY);

   // an overflow or an empty answer always closes the query
   `ASNF_ASSERT(a_ovf_last, clock, reset, (rsp_valid && (rsp_overflow || rsp_neighbor_number == '0) |-> rsp_last), "overflow or empty result not marked last")

   // a non-axial answer carries no neighbour count
   `ASNF_ASSERT(a_nonaxial, clock, reset, (rsp_valid && !rsp_is_axial |-> rsp_neighbor_count == '0), "non-axial result with a count")

   // intermediate results come only while the query is still running
   `ASNF_ASSERT(a_mid_busy, clock, reset, (rsp_valid && !rsp_last |-> busy && rsp_neighbor_count != '0), "intermediate result outside a running scan")

   // an accepted query holds the block and gives no result at once
   `ASNF_ASSERT(a_query_busy, clock, reset, (query_acc |=> busy && !rsp_valid), "query not taken up")

   // reset leaves the block idle and quiet
   `ASNF_ASSERT_ALWAYS(a_reset_idle, clock, (reset |=> !busy && !rsp_valid), "block not idle after reset")

endmodule

bind axial_straw_neighbor_finder asnf_checker #(
   .MAX_STRAWS    (MAX_STRAWS),
   .MAX_NEIGHBORS (MAX_NEIGHBORS),
   .POS_WIDTH     (POS_WIDTH)
) u_asnf_checker (
   .clock               (clock),
   .reset               (reset),
   .start               (start),
   .busy                (busy),
   .req_func            (req_func),
   .rsp_valid           (rsp_valid),
   .rsp_neighbor_number (rsp_neighbor_number),
   .rsp_neighbor_count  (rsp_neighbor_count),
   .rsp_is_axial        (rsp_is_axial),
   .rsp_overflow        (rsp_overflow),
   .rsp_last            (rsp_last)
);
